FILE: sv/u8ws_pkg.sv
// Shared types, constants and lookup functions for the UTF-8 word segmenter.
// No dependencies; every other file in the block uses this package.
`timescale 1ns / 1ps

package u8ws_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int OUT_BITS    = 16;
  localparam int CP_BITS     = 21;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 80;

  localparam logic [CP_BITS-1:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_BITS-1:0] CP_MAX         = 21'h10FFFF;
  localparam logic [9:0]         SURROGATE_HI   = 10'h01b;
  localparam logic [8:0]         CONT_EXPECT    = 9'h02a;
  localparam logic [22:0]        MIN_NO_LEAD    = 23'h400000;

  // Split characters
  localparam logic [CP_BITS-1:0] CH_TAB    = 21'h09;
  localparam logic [CP_BITS-1:0] CH_NL     = 21'h0a;
  localparam logic [CP_BITS-1:0] CH_SPACE  = 21'h20;
  localparam logic [CP_BITS-1:0] CH_BANG   = 21'h21;
  localparam logic [CP_BITS-1:0] CH_LPAREN = 21'h28;
  localparam logic [CP_BITS-1:0] CH_RPAREN = 21'h29;
  localparam logic [CP_BITS-1:0] CH_COMMA  = 21'h2c;
  localparam logic [CP_BITS-1:0] CH_DASH   = 21'h2d;
  localparam logic [CP_BITS-1:0] CH_DOT    = 21'h2e;
  localparam logic [CP_BITS-1:0] CH_COLON  = 21'h3a;
  localparam logic [CP_BITS-1:0] CH_SEMI   = 21'h3b;
  localparam logic [CP_BITS-1:0] CH_QUEST  = 21'h3f;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  // Decoder to segmenter
  typedef struct packed {
    logic [CP_BITS-1:0] cp;
    logic [2:0]         want;
    logic               err;
    logic               last;
  } dec_t;

  typedef struct packed {
    logic [CP_BITS-1:0]  code_point;
    logic [2:0]          consumed;
    logic                decode_error;
    logic                word_valid;
    logic [OUT_BITS-1:0] word_start;
    logic [OUT_BITS-1:0] word_length;
    logic                punct_valid;
    logic [OUT_BITS-1:0] punct_start;
    logic                offset_overflow;
  } res_t;

  // Sequence length from the top five bits of the lead byte, 0 for a bad lead
  function automatic logic [2:0] lead_len(input logic [4:0] hi);
    logic [2:0] n;
    case (hi) inside
      [5'd0:5'd15]:  n = 3'd1;
      [5'd24:5'd27]: n = 3'd2;
      [5'd28:5'd29]: n = 3'd3;
      5'd30:         n = 3'd4;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [6:0] lead_mask(input logic [2:0] n);
    logic [6:0] m;
    case (n)
      3'd1:    m = 7'h7f;
      3'd2:    m = 7'h1f;
      3'd3:    m = 7'h0f;
      3'd4:    m = 7'h07;
      default: m = 7'h00;
    endcase
    return m;
  endfunction

  function automatic logic [22:0] min_value(input logic [2:0] n);
    logic [22:0] v;
    case (n)
      3'd1:    v = 23'h0;
      3'd2:    v = 23'h80;
      3'd3:    v = 23'h800;
      3'd4:    v = 23'h10000;
      default: v = MIN_NO_LEAD;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] cp_shift(input logic [2:0] n);
    logic [4:0] s;
    case (n)
      3'd1:    s = 5'd18;
      3'd2:    s = 5'd12;
      3'd3:    s = 5'd6;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] err_shift(input logic [2:0] n);
    logic [2:0] s;
    case (n)
      3'd1:    s = 3'd6;
      3'd2:    s = 3'd4;
      3'd3:    s = 3'd2;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  function automatic logic is_space(input logic [CP_BITS-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

  function automatic logic is_punct(input logic [CP_BITS-1:0] c);
    return (c == CH_DOT) || (c == CH_COMMA) || (c == CH_SEMI) || (c == CH_COLON) ||
           (c == CH_BANG) || (c == CH_QUEST) || (c == CH_DASH) ||
           (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

  // Offsets go out as 16 bits whatever the internal width
  function automatic logic [OUT_BITS-1:0] to_out(input offset_t x);
    logic [OFFSET_BITS+OUT_BITS-1:0] t;
    t = {{OUT_BITS{1'b0}}, x};
    return t[OUT_BITS-1:0];
  endfunction

endpackage

FILE: sv/u8ws_decode.sv
// UTF-8 character decoder: window bytes in, code point, length and error out.
// Purely combinational; uses u8ws_pkg for tables and the dec_t struct.
`timescale 1ns / 1ps

module u8ws_decode (
  input  logic [7:0]      byte0,
  input  logic [7:0]      byte1,
  input  logic [7:0]      byte2,
  input  logic [7:0]      byte3,
  input  logic [2:0]      bytes_left,
  output u8ws_pkg::dec_t  dec
);

  logic [2:0]  left;
  logic [7:0]  s0, s1, s2, s3;
  logic [2:0]  len;
  logic [2:0]  base;
  logic [24:0] raw;
  logic [24:0] shifted;
  logic [20:0] cp;
  logic [8:0]  e;
  logic [8:0]  e_sh;
  logic        err;
  logic [2:0]  nz;
  logic [2:0]  want;

  always_comb begin
    left = (bytes_left == 3'd0) ? 3'd1 : bytes_left;
    s0 = byte0;
    s1 = (left >= 3'd2) ? byte1 : 8'h00;
    s2 = (left >= 3'd3) ? byte2 : 8'h00;
    s3 = (left >= 3'd4) ? byte3 : 8'h00;

    len  = u8ws_pkg::lead_len(s0[7:3]);
    base = (len == 3'd0) ? 3'd1 : len;

    raw     = {s0[6:0] & u8ws_pkg::lead_mask(len), s1[5:0], s2[5:0], s3[5:0]};
    shifted = raw >> u8ws_pkg::cp_shift(len);
    cp      = shifted[20:0];

    // Continuation checks expect 10 in the top two bits of each trailing byte
    e = {cp > u8ws_pkg::CP_MAX,
         cp[20:11] == u8ws_pkg::SURROGATE_HI,
         {2'b00, cp} < u8ws_pkg::min_value(len),
         s1[7:6], s2[7:6], s3[7:6]} ^ u8ws_pkg::CONT_EXPECT;
    e_sh = e >> u8ws_pkg::err_shift(len);
    err  = (e_sh != 9'd0);

    nz = {2'b00, s0 != 8'h00} + {2'b00, s1 != 8'h00} +
         {2'b00, s2 != 8'h00} + {2'b00, s3 != 8'h00};

    want = base;
    if (err) begin
      if (nz < want) begin
        want = nz;
      end
      if (want == 3'd0) begin
        want = 3'd1;
      end
    end

    dec.cp   = err ? u8ws_pkg::CP_REPLACEMENT : cp;
    dec.want = want;
    dec.err  = err;
    dec.last = (left <= 3'd4) && (left <= want);
  end

endmodule

FILE: sv/u8ws_segment.sv
// Word and punctuation segmenter: holds text offset and open-word state.
// Takes a dec_t from u8ws_decode, returns a res_t; uses u8ws_pkg.
`timescale 1ns / 1ps

module u8ws_segment (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            start_of_text,
  input  u8ws_pkg::dec_t  dec,
  output u8ws_pkg::res_t  res
);

  localparam int OB = u8ws_pkg::OFFSET_BITS;

  u8ws_pkg::offset_t position, position_next;
  u8ws_pkg::offset_t word_base, word_base_next;
  u8ws_pkg::offset_t word_len, word_len_next;
  logic              overflow, overflow_next;

  u8ws_pkg::offset_t pos, cws, cwl;
  logic              ovf;
  logic [OB:0]       pos_sum, len_sum;
  u8ws_pkg::offset_t pos_sat, len_sat, start;
  logic              split, punct;
  logic              wv, pv;
  u8ws_pkg::offset_t ws, wl, ps;

  always_comb begin
    // New text clears everything before this character is placed
    pos = start_of_text ? '0 : position;
    cws = start_of_text ? '0 : word_base;
    cwl = start_of_text ? '0 : word_len;
    ovf = start_of_text ? 1'b0 : overflow;

    pos_sum = {1'b0, pos} + {{(OB-2){1'b0}}, dec.want};
    len_sum = {1'b0, cwl} + {{(OB-2){1'b0}}, dec.want};
    pos_sat = pos_sum[OB] ? '1 : pos_sum[OB-1:0];
    len_sat = len_sum[OB] ? '1 : len_sum[OB-1:0];
    start   = (cwl == '0) ? pos : cws;

    punct = u8ws_pkg::is_punct(dec.cp);
    split = punct || u8ws_pkg::is_space(dec.cp);

    wv = 1'b0;
    ws = '0;
    wl = '0;
    pv = 1'b0;
    ps = '0;
    word_base_next = cws;
    word_len_next  = cwl;
    overflow_next  = ovf | pos_sum[OB];
    position_next  = pos_sat;

    if (split) begin
      if (cwl != '0) begin
        wv = 1'b1;
        ws = cws;
        wl = cwl;
        word_len_next = '0;
      end
      if (punct) begin
        pv = 1'b1;
        ps = pos;
      end
      word_base_next = pos_sat;
    end else begin
      overflow_next = ovf | pos_sum[OB] | len_sum[OB];
      if (dec.last) begin
        // Close the open word with the final character
        wv = 1'b1;
        ws = start;
        wl = len_sat;
        word_len_next  = '0;
        word_base_next = pos_sat;
      end else begin
        word_base_next = start;
        word_len_next  = len_sat;
      end
    end

    res.code_point      = dec.cp;
    res.consumed        = dec.want;
    res.decode_error    = dec.err;
    res.word_valid      = wv;
    res.word_start      = u8ws_pkg::to_out(ws);
    res.word_length     = u8ws_pkg::to_out(wl);
    res.punct_valid     = pv;
    res.punct_start     = u8ws_pkg::to_out(ps);
    res.offset_overflow = overflow_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      word_base <= '0;
      word_len  <= '0;
      overflow  <= 1'b0;
    end else if (advance) begin
      position  <= position_next;
      word_base <= word_base_next;
      word_len  <= word_len_next;
      overflow  <= overflow_next;
    end
  end

endmodule

FILE: sv/utf8_word_segmenter.sv
// UTF-8 word segmenter top level: input beat register, decode, segment, result register.
// Instantiates u8ws_decode and u8ws_segment; uses u8ws_pkg.
`timescale 1ns / 1ps

// Decodes one UTF-8 character per beat from a four-byte window and reports
// word and punctuation blocks as byte offsets. One beat is taken every clock
// cycle while m_tready lets results drain; the beat lands in the input
// register and its result in the result register when it moves on. While a
// result waits on m_tready the block holds at most one further beat in its
// input register and then drops s_tready. The rate is set by the update of
// the offset and open-word state, which each character reads and writes in
// the cycle it leaves the input register.
// Advance the window by the consumed count before the next beat.

module utf8_word_segmenter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [7:0] byte0, [15:8] byte1, [23:16] byte2, [31:24] byte3,
  // [34:32] bytes_left, [39:35] zero
  input  logic [u8ws_pkg::IN_DATA_W-1:0]   s_tdata,
  // [0] start_of_text
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [20:0] code_point, [23:21] consumed, [24] decode_error, [25] word_valid,
  // [41:26] word_start, [57:42] word_length, [58] punct_valid,
  // [74:59] punct_start, [75] offset_overflow, [79:76] zero
  output logic [u8ws_pkg::OUT_DATA_W-1:0]  m_tdata
);

  logic                            in_valid, in_valid_next;
  logic [34:0]                     in_data;
  logic                            in_sot;
  logic                            out_free;
  logic                            advance;
  logic                            out_valid_next;
  u8ws_pkg::dec_t                  dec;
  u8ws_pkg::res_t                  res;
  logic [u8ws_pkg::OUT_DATA_W-1:0] packed_res;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || advance;

  always_comb begin
    in_valid_next = in_valid;
    if (s_tvalid && s_tready) begin
      in_valid_next = 1'b1;
    end else if (advance) begin
      in_valid_next = 1'b0;
    end
    out_valid_next = m_tvalid;
    if (advance) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
      m_tvalid <= out_valid_next;
    end
  end

  // Payload registers: hold the beat until it moves on
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata[34:0];
      in_sot  <= s_tuser;
    end
    if (advance) begin
      m_tdata <= packed_res;
    end
  end

  u8ws_decode u_decode (
    .byte0      (in_data[7:0]),
    .byte1      (in_data[15:8]),
    .byte2      (in_data[23:16]),
    .byte3      (in_data[31:24]),
    .bytes_left (in_data[34:32]),
    .dec        (dec)
  );

  u8ws_segment u_segment (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .start_of_text (in_sot),
    .dec           (dec),
    .res           (res)
  );

  assign packed_res = {4'b0000,
                       res.offset_overflow,
                       res.punct_start,
                       res.punct_valid,
                       res.word_length,
                       res.word_start,
                       res.word_valid,
                       res.decode_error,
                       res.consumed,
                       res.code_point};

  a_consumed_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:21] != 3'd0) && (m_tdata[23:21] <= 3'd4))
    else $error("consumed count out of range");

  a_error_replacement: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[24]) |-> (m_tdata[20:0] == u8ws_pkg::CP_REPLACEMENT))
    else $error("decode error without replacement character");

  a_no_word_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[25]) |-> (m_tdata[57:26] == 32'd0))
    else $error("word fields set without a word block");

  a_punct_not_space: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[58]) |->
      (m_tdata[20:0] != u8ws_pkg::CH_SPACE) && (m_tdata[20:0] != u8ws_pkg::CH_TAB) &&
      (m_tdata[20:0] != u8ws_pkg::CH_NL))
    else $error("whitespace reported as punctuation block");

  a_result_follows_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("result lost after an input beat moved on");

endmodule

FILE: tb/segment_checker.sv
// Checker for the UTF-8 word segmenter: watches both stream channels, predicts each result
// from the accepted input beats and compares it. Uses u8ws_pkg for types and constants.
`timescale 1ns / 1ps

module segment_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // [7:0] byte0, [15:8] byte1, [23:16] byte2, [31:24] byte3,
  // [34:32] bytes_left, [39:35] zero
  input  logic [39:0] s_tdata,
  // [0] start_of_text
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // [20:0] code_point, [23:21] consumed, [24] decode_error, [25] word_valid,
  // [41:26] word_start, [57:42] word_length, [58] punct_valid,
  // [74:59] punct_start, [75] offset_overflow, [79:76] zero
  input  logic [79:0] m_tdata,
  output int          mismatches,
  output int          outstanding
);

  u8ws_pkg::offset_t text_pos;
  u8ws_pkg::offset_t open_start;
  u8ws_pkg::offset_t open_len;
  logic              sat_seen;
  u8ws_pkg::res_t    expected_q[$];

  function automatic u8ws_pkg::offset_t clamp_add(input u8ws_pkg::offset_t a,
                                                   input logic [2:0] b);
    logic [u8ws_pkg::OFFSET_BITS:0] sum;
    sum = {1'b0, a} + b;
    if (sum > {1'b0, {u8ws_pkg::OFFSET_BITS{1'b1}}}) begin
      sat_seen = 1'b1;
      return '1;
    end
    return sum[u8ws_pkg::OFFSET_BITS-1:0];
  endfunction

  function automatic u8ws_pkg::res_t decode_and_segment(input logic [39:0] beat,
                                                         input logic fresh);
    logic [7:0]        win [4];
    logic [2:0]        left;
    logic [2:0]        seq_len;
    logic [2:0]        take;
    logic [20:0]       cp;
    logic              bad;
    logic              split;
    logic              punct;
    logic              last;
    int                i;
    int                nonzero;
    u8ws_pkg::offset_t here;
    u8ws_pkg::res_t    r;
    r = '0;
    left = (beat[34:32] == 3'd0) ? 3'd1 : beat[34:32];
    if (fresh) begin
      text_pos   = '0;
      open_start = '0;
      open_len   = '0;
      sat_seen   = 1'b0;
    end
    // bytes at or past the end of the text read as zero
    for (i = 0; i < 4; i++) win[i] = (i < left) ? beat[8*i +: 8] : 8'h00;

    if (!win[0][7])                    seq_len = 3'd1;
    else if (win[0][7:5] == 3'b110)    seq_len = 3'd2;
    else if (win[0][7:4] == 4'b1110)   seq_len = 3'd3;
    else if (win[0][7:3] == 5'b11110)  seq_len = 3'd4;
    else                               seq_len = 3'd0;

    case (seq_len)
      3'd1:    cp = {14'd0, win[0][6:0]};
      3'd2:    cp = {10'd0, win[0][4:0], win[1][5:0]};
      3'd3:    cp = {5'd0, win[0][3:0], win[1][5:0], win[2][5:0]};
      3'd4:    cp = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
      default: cp = {3'd0, win[1][5:0], win[2][5:0], win[3][5:0]};
    endcase

    bad = 1'b0;
    case (seq_len)
      3'd0: bad = 1'b1;
      3'd1: bad = 1'b0;
      default: begin
        for (i = 1; i < seq_len; i++) if (win[i][7:6] != 2'b10) bad = 1'b1;
        if (cp[20:11] == u8ws_pkg::SURROGATE_HI || cp > u8ws_pkg::CP_MAX) bad = 1'b1;
        // overlong: value fits a shorter form
        if ((seq_len == 3'd2 && cp < 21'h80) || (seq_len == 3'd3 && cp < 21'h800) ||
            (seq_len == 3'd4 && cp < 21'h10000)) bad = 1'b1;
      end
    endcase

    take = (seq_len == 3'd0) ? 3'd1 : seq_len;
    if (bad) begin
      // skip no further than the nonzero bytes of the window
      nonzero = (win[0] != 0) + (win[1] != 0) + (win[2] != 0) + (win[3] != 0);
      if (nonzero < take) take = 3'(nonzero);
      if (take == 3'd0) take = 3'd1;
      cp = u8ws_pkg::CP_REPLACEMENT;
    end

    here = text_pos;
    case (cp)
      u8ws_pkg::CH_SPACE, u8ws_pkg::CH_TAB, u8ws_pkg::CH_NL: begin
        split = 1'b1;
        punct = 1'b0;
      end
      u8ws_pkg::CH_DOT, u8ws_pkg::CH_COMMA, u8ws_pkg::CH_SEMI, u8ws_pkg::CH_COLON,
      u8ws_pkg::CH_BANG, u8ws_pkg::CH_QUEST, u8ws_pkg::CH_DASH, u8ws_pkg::CH_LPAREN,
      u8ws_pkg::CH_RPAREN: begin
        split = 1'b1;
        punct = 1'b1;
      end
      default: begin
        split = 1'b0;
        punct = 1'b0;
      end
    endcase
    last = (left <= 3'd4) && (left <= take);

    if (split) begin
      if (open_len != '0) begin
        r.word_valid  = 1'b1;
        r.word_start  = open_start;
        r.word_length = open_len;
        open_len      = '0;
      end
      if (punct) begin
        r.punct_valid = 1'b1;
        r.punct_start = here;
      end
      open_start = clamp_add(here, take);
    end else begin
      if (open_len == '0) open_start = here;
      open_len = clamp_add(open_len, take);
      // close the open word on the final character of the text
      if (last) begin
        r.word_valid  = 1'b1;
        r.word_start  = open_start;
        r.word_length = open_len;
        open_len      = '0;
        open_start    = clamp_add(here, take);
      end
    end
    text_pos = clamp_add(here, take);

    r.code_point      = cp;
    r.consumed        = take;
    r.decode_error    = bad;
    r.offset_overflow = sat_seen;
    return r;
  endfunction

  task automatic flag_failure(input string why, input u8ws_pkg::res_t e,
                              input u8ws_pkg::res_t a);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, why);
      $display("  expected cp=%h cons=%0d err=%b word=%b/%0d/%0d punct=%b/%0d ovf=%b",
               e.code_point, e.consumed, e.decode_error, e.word_valid, e.word_start,
               e.word_length, e.punct_valid, e.punct_start, e.offset_overflow);
      $display("  actual   cp=%h cons=%0d err=%b word=%b/%0d/%0d punct=%b/%0d ovf=%b",
               a.code_point, a.consumed, a.decode_error, a.word_valid, a.word_start,
               a.word_length, a.punct_valid, a.punct_start, a.offset_overflow);
    end
  endtask

  always @(posedge clk) begin : watch
    u8ws_pkg::res_t got;
    u8ws_pkg::res_t due;
    u8ws_pkg::res_t nxt;
    if (rst) begin
      text_pos   = '0;
      open_start = '0;
      open_len   = '0;
      sat_seen   = 1'b0;
      expected_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.code_point      = m_tdata[20:0];
        got.consumed        = m_tdata[23:21];
        got.decode_error    = m_tdata[24];
        got.word_valid      = m_tdata[25];
        got.word_start      = m_tdata[41:26];
        got.word_length     = m_tdata[57:42];
        got.punct_valid     = m_tdata[58];
        got.punct_start     = m_tdata[74:59];
        got.offset_overflow = m_tdata[75];
        if (expected_q.size() == 0) begin
          flag_failure("result beat with none expected", '0, got);
        end else begin
          due = expected_q.pop_front();
          if (got !== due) flag_failure("result beat mismatch", due, got);
        end
      end
      if (s_tvalid && s_tready) begin
        nxt = decode_and_segment(s_tdata, s_tuser);
        expected_q = {expected_q, nxt};
      end
    end
    outstanding = expected_q.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the UTF-8 word segmenter testbench: clock, reset, text stimulus and verdict.
// Depends on u8ws_pkg, utf8_word_segmenter and segment_checker.
`timescale 1ns / 1ps

module testbench;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;
  int          mismatches;
  int          outstanding;

  logic        idle_on;
  int          stall_left;
  int          items_sent;
  logic [7:0]  text_bytes[$];
  int          char_starts[$];

  utf8_word_segmenter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  segment_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // receiver back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 18);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    #5_000_000;
    $display("[utf8_word_segmenter] ERROR");
    $finish;
  end

  task automatic send_beat(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                           input logic [7:0] b3, input logic [2:0] left, input logic sot);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, left, b3, b2, b1, b0};
    s_tuser  <= sot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // drop valid and hold until every result is back
  task automatic drain();
    @(negedge clk) s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // append one byte to the text
  task automatic put_byte(input logic [7:0] b);
    text_bytes = {text_bytes, b};
  endtask

  // encode cp in exactly n bytes, overlong forms included
  task automatic put_cp(input logic [20:0] cp, input int n);
    case (n)
      1: put_byte({1'b0, cp[6:0]});
      2: begin
        put_byte({3'b110, cp[10:6]});
        put_byte({2'b10, cp[5:0]});
      end
      3: begin
        put_byte({4'b1110, cp[15:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
      default: begin
        put_byte({5'b11110, cp[20:18]});
        put_byte({2'b10, cp[17:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic logic [20:0] pick_split(input int idx);
    case (idx)
      0:       return u8ws_pkg::CH_SPACE;
      1:       return u8ws_pkg::CH_TAB;
      2:       return u8ws_pkg::CH_NL;
      3:       return u8ws_pkg::CH_DOT;
      4:       return u8ws_pkg::CH_COMMA;
      5:       return u8ws_pkg::CH_SEMI;
      6:       return u8ws_pkg::CH_COLON;
      7:       return u8ws_pkg::CH_BANG;
      8:       return u8ws_pkg::CH_QUEST;
      9:       return u8ws_pkg::CH_DASH;
      10:      return u8ws_pkg::CH_LPAREN;
      default: return u8ws_pkg::CH_RPAREN;
    endcase
  endfunction

  task automatic add_char();
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    char_starts = {char_starts, text_bytes.size()};
    if (roll < 40)      put_cp(21'($urandom_range(8'h61, 8'h7a)), 1);
    else if (roll < 50) put_cp(21'($urandom_range(0, 8'h7f)), 1);
    else if (roll < 65) put_cp(pick_split(int'($urandom_range(0, 11))), 1);
    else if (roll < 73) put_cp(21'($urandom_range(21'h80, 21'h7ff)), 2);
    else if (roll < 81) put_cp(21'($urandom_range(21'h800, 21'hffff)), 3);
    else if (roll < 88) put_cp(21'($urandom_range(21'h10000, 21'h10ffff)), 4);
    else begin
      case ($urandom_range(0, 5))
        0: put_byte(8'($urandom_range(8'h80, 8'hbf)));
        1: put_byte(8'($urandom_range(8'hf8, 8'hff)));
        2: begin
          // lead cut short by the next character
          put_byte(8'he2);
          put_byte(8'($urandom_range(8'h80, 8'hbf)));
        end
        3: begin
          n = $urandom_range(2, 4);
          put_cp(21'($urandom_range(0, (n == 2) ? 21'h7f : (n == 3) ? 21'h7ff : 21'hffff)),
                 n);
        end
        4: put_cp(21'($urandom_range(21'h110000, 21'h1fffff)), 4);
        default: repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // slide the window over the text one character at a time, then drop the text
  task automatic feed_text();
    int         k;
    int         i;
    int         p;
    int         rem;
    logic [2:0] left;
    logic [7:0] w [4];
    for (k = 0; k < char_starts.size(); k++) begin
      p   = char_starts[k];
      rem = text_bytes.size() - p;
      for (i = 0; i < 4; i++)
        w[i] = (p + i < text_bytes.size()) ? text_bytes[p + i] : 8'($urandom_range(0, 255));
      if (rem < 5)                          left = 3'(rem);
      else if ($urandom_range(0, 5) == 0)   left = 3'($urandom_range(5, 7));
      else                                  left = 3'd5;
      send_beat(w[0], w[1], w[2], w[3], left, k == 0);
    end
    text_bytes.delete();
    char_starts.delete();
  endtask

  initial begin : stimulus
    int   base;
    logic paused;
    clk        = 1'b0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    m_tready   = 1'b0;
    idle_on    = 1'b0;
    stall_left = 0;
    items_sent = 0;
    paused     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: word and punctuation boundaries, decode extremes and errors
    idle_on = 1'b1;
    send_beat(8'h41, 8'h62, 8'(u8ws_pkg::CH_DOT), 8'h20, 3'd5, 1'b1);
    send_beat(8'h62, 8'(u8ws_pkg::CH_DOT), 8'h00, 8'h00, 3'd5, 1'b0);
    send_beat(8'(u8ws_pkg::CH_DOT), 8'h20, 8'h00, 8'h00, 3'd5, 1'b0);
    send_beat(8'(u8ws_pkg::CH_SPACE), 8'hff, 8'hff, 8'hff, 3'd5, 1'b0);
    send_beat(8'(u8ws_pkg::CH_LPAREN), 8'h80, 8'h80, 8'h80, 3'd5, 1'b0);
    send_beat(8'hc2, 8'h80, 8'h00, 8'h00, 3'd5, 1'b0);
    send_beat(8'hdf, 8'hbf, 8'h41, 8'h41, 3'd5, 1'b0);
    send_beat(8'he0, 8'ha0, 8'h80, 8'h00, 3'd5, 1'b0);
    send_beat(8'hef, 8'hbf, 8'hbf, 8'hff, 3'd5, 1'b0);
    send_beat(8'hf0, 8'h90, 8'h80, 8'h80, 3'd5, 1'b0);
    send_beat(8'hf4, 8'h8f, 8'hbf, 8'hbf, 3'd5, 1'b0);
    send_beat(8'hf4, 8'h90, 8'h80, 8'h80, 3'd5, 1'b0);
    send_beat(8'hed, 8'ha0, 8'h80, 8'h00, 3'd5, 1'b0);
    send_beat(8'hc0, 8'h80, 8'h00, 8'h00, 3'd5, 1'b0);
    send_beat(8'he0, 8'h80, 8'h80, 8'h00, 3'd5, 1'b0);
    send_beat(8'hf0, 8'h80, 8'h80, 8'h80, 3'd5, 1'b0);
    send_beat(8'h80, 8'h80, 8'h80, 8'h80, 3'd5, 1'b0);
    send_beat(8'hc2, 8'h41, 8'h00, 8'h00, 3'd5, 1'b0);
    send_beat(8'hff, 8'hff, 8'hff, 8'hff, 3'd7, 1'b0);
    send_beat(8'he2, 8'h82, 8'h00, 8'h00, 3'd5, 1'b0);
    send_beat(8'he2, 8'h82, 8'hac, 8'h55, 3'd2, 1'b0);
    send_beat(8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b0);
    send_beat(8'(u8ws_pkg::CH_TAB), 8'h78, 8'h00, 8'h00, 3'd5, 1'b0);
    send_beat(8'h78, 8'hff, 8'hff, 8'hff, 3'd1, 1'b0);
    send_beat(8'h79, 8'hff, 8'hff, 8'hff, 3'd1, 1'b1);
    send_beat(8'(u8ws_pkg::CH_NL), 8'h00, 8'h00, 8'h00, 3'd6, 1'b1);

    // random texts with some loose beats between them
    base = items_sent;
    while (items_sent - base < 880) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (!paused && items_sent - base >= 440) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_beat(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  3'($urandom_range(0, 7)), $urandom_range(0, 3) == 0);
      end else begin
        repeat ($urandom_range(1, 30)) add_char();
        feed_text();
      end
    end

    // last texts at full rate on both sides
    idle_on = 1'b0;
    repeat (6) begin
      repeat ($urandom_range(1, 30)) add_char();
      feed_text();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[utf8_word_segmenter] OK");
    end else begin
      $display("[utf8_word_segmenter] ERROR");
    end
    $finish;
  end

endmodule
